// ----- src/dhss_pkg.sv -----
`default_nettype none

package dhss_pkg;

    localparam int SYM_W       = 2;
    localparam int SYMBOLS_W   = 24;
    localparam int LENGTH_W    = 4;
    localparam int MAX_SYMBOLS = 12;
    localparam int TABLE_SIZE_DEF = 4096;

    // A key of MAX_SYMBOLS base-5 digits stays below 5**12, which needs 28 bits.
    localparam int KEY_W = 28;

    typedef enum logic
    {
        OP_FIND   = 1'b0,
        OP_INSERT = 1'b1
    } opcode_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_SEEK,
        ST_PROBE,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- src/dhss_req_if.sv -----
`default_nettype none

interface dhss_req_if;

    logic                               valid;
    logic                               ready;
    logic                               opcode;
    logic [dhss_pkg::SYMBOLS_W-1:0]     symbols;
    logic [dhss_pkg::LENGTH_W-1:0]      length;

    modport source
    (
        output valid,
        output opcode,
        output symbols,
        output length,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  opcode,
        input  symbols,
        input  length,
        output ready
    );

endinterface

`default_nettype wire

// ----- src/dhss_rsp_if.sv -----
`default_nettype none

interface dhss_rsp_if;

    logic valid;
    logic ready;
    logic found;
    logic full_res;

    modport source
    (
        output valid,
        output found,
        output full_res,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  found,
        input  full_res,
        output ready
    );

endinterface

`default_nettype wire

// ----- src/double_hash_string_set.sv -----
// Set of DNA strings of 1 to 12 symbols kept as base-5 keys in an open-addressed table of
// TABLE_SIZE entries with double hashing; each request beat is a find or an insert and gives
// one response beat with found and full_res. After reset the table is swept to empty, one
// entry per cycle, with req.ready low. A request then folds its L symbols into the key and
// both hash residues, one symbol per cycle, then makes P probes, one per cycle on the table
// memory (one read and one write port), up to TABLE_SIZE, and then answers. A request of
// length zero changes nothing and goes straight to the answer.
`default_nettype none

module double_hash_string_set #(
    parameter int TABLE_SIZE = dhss_pkg::TABLE_SIZE_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    dhss_req_if.sink   req,
    dhss_rsp_if.source rsp
);

    localparam int IW    = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam int RES_W = IW + 3;
    localparam int KEY_W = dhss_pkg::KEY_W;

    localparam logic [RES_W-1:0] N1 = RES_W'(TABLE_SIZE);
    localparam logic [RES_W-1:0] N2 = RES_W'(2 * TABLE_SIZE);
    localparam logic [RES_W-1:0] N3 = RES_W'(3 * TABLE_SIZE);
    localparam logic [RES_W-1:0] N4 = RES_W'(4 * TABLE_SIZE);
    localparam logic [RES_W-1:0] M1 = RES_W'(TABLE_SIZE - 1);
    localparam logic [RES_W-1:0] M2 = RES_W'(2 * (TABLE_SIZE - 1));
    localparam logic [RES_W-1:0] M3 = RES_W'(3 * (TABLE_SIZE - 1));
    localparam logic [RES_W-1:0] M4 = RES_W'(4 * (TABLE_SIZE - 1));
    localparam logic [IW-1:0]    LAST_ADDR = IW'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0] PROBE_CAP = CNT_W'(TABLE_SIZE);

    // One Horner step leaves a value below five times the modulus.
    function automatic logic [IW-1:0] reduce5(
        input logic [RES_W-1:0] v,
        input logic [RES_W-1:0] m1,
        input logic [RES_W-1:0] m2,
        input logic [RES_W-1:0] m3,
        input logic [RES_W-1:0] m4
    );
        logic [RES_W-1:0] r;
        if (v >= m4)
        begin
            r = v - m4;
        end
        else if (v >= m3)
        begin
            r = v - m3;
        end
        else if (v >= m2)
        begin
            r = v - m2;
        end
        else if (v >= m1)
        begin
            r = v - m1;
        end
        else
        begin
            r = v;
        end
        return r[IW-1:0];
    endfunction

    dhss_pkg::state_t state_reg, state_next;

    logic                           op_reg, op_next;
    logic [dhss_pkg::SYMBOLS_W-1:0] sym_reg, sym_next;
    logic [dhss_pkg::LENGTH_W-1:0]  pos_reg, pos_next;
    logic [KEY_W-1:0]               key_reg, key_next;
    logic [IW-1:0]                  rn_reg, rn_next;
    logic [IW-1:0]                  rm_reg, rm_next;
    logic [IW-1:0]                  idx_reg, idx_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [IW-1:0]                  clr_reg, clr_next;
    logic                           res_found_reg, res_found_next;
    logic                           res_full_reg, res_full_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_found_reg, out_found_next;
    logic                           out_full_reg, out_full_next;

    logic [KEY_W-1:0] mem [TABLE_SIZE];
    logic [KEY_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [KEY_W-1:0] mem_wdata;
    logic [IW-1:0]    mem_raddr;

    logic [dhss_pkg::LENGTH_W-1:0] len_sat;
    logic [dhss_pkg::SYM_W-1:0]    sym_cur;
    logic [2:0]                    digit;
    logic [RES_W-1:0]              vn;
    logic [RES_W-1:0]              vm;
    logic [IW-1:0]                 stride;
    logic [IW:0]                   idx_sum;
    logic [IW-1:0]                 idx_step;
    logic                          hit;
    logic                          empty;
    logic                          cap;
    logic                          accept;
    logic                          out_free;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign hit      = (rd_data_reg == key_reg);
    assign empty    = (rd_data_reg == '0);
    assign cap      = (cnt_reg == PROBE_CAP);

    assign len_sat = (req.length > dhss_pkg::LENGTH_W'(dhss_pkg::MAX_SYMBOLS))
                   ? dhss_pkg::LENGTH_W'(dhss_pkg::MAX_SYMBOLS) : req.length;

    assign sym_cur = dhss_pkg::SYM_W'(sym_reg >> {pos_reg, 1'b0});
    assign digit   = {1'b0, sym_cur} + 3'd1;
    assign vn      = RES_W'({rn_reg, 2'b00}) + RES_W'(rn_reg) + RES_W'(digit);
    assign vm      = RES_W'({rm_reg, 2'b00}) + RES_W'(rm_reg) + RES_W'(digit);

    assign stride   = rm_reg + IW'(1);
    assign idx_sum  = {1'b0, idx_reg} + {1'b0, stride};
    assign idx_step = (idx_sum >= (IW + 1)'(TABLE_SIZE))
                    ? IW'(idx_sum - (IW + 1)'(TABLE_SIZE)) : idx_sum[IW-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dhss_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = dhss_pkg::ST_IDLE;
                end
            end
            dhss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.length == '0) ? dhss_pkg::ST_EMIT : dhss_pkg::ST_HASH;
                end
            end
            dhss_pkg::ST_HASH:
            begin
                if (pos_reg == '0)
                begin
                    state_next = dhss_pkg::ST_SEEK;
                end
            end
            dhss_pkg::ST_SEEK:
            begin
                state_next = dhss_pkg::ST_PROBE;
            end
            dhss_pkg::ST_PROBE:
            begin
                if (hit || empty || cap)
                begin
                    state_next = dhss_pkg::ST_EMIT;
                end
            end
            dhss_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = dhss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dhss_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = key_reg;
        mem_raddr = idx_reg;
        case (state_reg)
            dhss_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            dhss_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            dhss_pkg::ST_SEEK:
            begin
                mem_raddr = rn_reg;
            end
            dhss_pkg::ST_PROBE:
            begin
                mem_raddr = idx_step;
                mem_we    = !hit && empty && (op_reg == dhss_pkg::OP_INSERT);
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        sym_next       = sym_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        rn_next        = rn_reg;
        rm_next        = rm_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        res_found_next = res_found_reg;
        res_full_next  = res_full_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_found_next = out_found_reg;
        out_full_next  = out_full_reg;
        case (state_reg)
            dhss_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + IW'(1);
            end
            dhss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next        = req.opcode;
                    sym_next       = req.symbols;
                    pos_next       = len_sat - dhss_pkg::LENGTH_W'(1);
                    key_next       = '0;
                    rn_next        = '0;
                    rm_next        = '0;
                    res_found_next = 1'b0;
                    res_full_next  = 1'b0;
                end
            end
            dhss_pkg::ST_HASH:
            begin
                key_next = (key_reg << 2) + key_reg + KEY_W'(digit);
                rn_next  = reduce5(vn, N1, N2, N3, N4);
                rm_next  = reduce5(vm, M1, M2, M3, M4);
                pos_next = pos_reg - dhss_pkg::LENGTH_W'(1);
            end
            dhss_pkg::ST_SEEK:
            begin
                idx_next = rn_reg;
                cnt_next = CNT_W'(1);
            end
            dhss_pkg::ST_PROBE:
            begin
                if (hit || empty || cap)
                begin
                    res_found_next = hit;
                    res_full_next  = !hit && !empty;
                end
                else
                begin
                    idx_next = idx_step;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            dhss_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_full_next  = res_full_reg;
                end
            end
            default:
            begin
                clr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dhss_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        sym_reg       <= sym_next;
        pos_reg       <= pos_next;
        key_reg       <= key_next;
        rn_reg        <= rn_next;
        rm_reg        <= rm_next;
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        res_found_reg <= res_found_next;
        res_full_reg  <= res_full_next;
        out_found_reg <= out_found_next;
        out_full_reg  <= out_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.found    = out_found_reg;
    assign rsp.full_res = out_full_reg;

    a_write_only_clear_or_probe: assert property (
        @(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == dhss_pkg::ST_CLEAR || state_reg == dhss_pkg::ST_PROBE)
    ) else $error("Table written outside the clearing pass or a probe.");

    a_found_excludes_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.found && rsp.full_res)
    ) else $error("Response beat reports both found and full.");

    a_probe_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == dhss_pkg::ST_PROBE) |->
            (idx_reg <= LAST_ADDR && cnt_reg != '0 && cnt_reg <= PROBE_CAP && stride != '0)
    ) else $error("Probe index, stride or count out of range.");

    a_accept_starts_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == dhss_pkg::ST_HASH || state_reg == dhss_pkg::ST_EMIT)
    ) else $error("Accepted request did not start hashing or answering.");

    a_insert_key_written: assert property (
        @(posedge clk) disable iff (!rst_n)
        mem_we && (state_reg == dhss_pkg::ST_PROBE) |-> (mem_wdata != '0 && !hit)
    ) else $error("Insert writes an empty key or a key already present.");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int TABLE_N = dhss_pkg::TABLE_SIZE_DEF;

    typedef struct packed
    {
        logic found;
        logic full_res;
    } answer_t;

    typedef struct packed
    {
        logic [dhss_pkg::SYMBOLS_W-1:0] symbols;
        logic [dhss_pkg::LENGTH_W-1:0]  length;
    } dna_string_t;

    logic clk;
    logic rst_n;

    dhss_req_if req();
    dhss_rsp_if rsp();

    double_hash_string_set #(
        .TABLE_SIZE(TABLE_N)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    logic [dhss_pkg::KEY_W-1:0] stored_keys [TABLE_N];
    answer_t                    pending_answers [$];
    dna_string_t                inserted_strings [$];
    int                         send_idle_pct;
    int                         recv_stall_pct;
    int                         mismatch_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(250_000_000);
        $display("FAILURE");
        $finish;
    end

    function automatic longint unsigned dna_key(logic [dhss_pkg::SYMBOLS_W-1:0] symbols,
                                                int len);
        longint unsigned key;
        longint unsigned weight;
        key = 0;
        weight = 1;
        for (int p = 0; p < len; p++)
        begin
            key += weight * (longint'(symbols[2*p +: 2]) + 1);
            weight *= 5;
        end
        return key;
    endfunction

    function automatic answer_t lookup_string(dhss_pkg::opcode_t op,
                                              logic [dhss_pkg::SYMBOLS_W-1:0] symbols,
                                              logic [dhss_pkg::LENGTH_W-1:0] length);
        answer_t         answer;
        int              len;
        longint unsigned key;
        longint unsigned home;
        longint unsigned stride;
        longint unsigned slot;
        answer = '0;
        len = (length > dhss_pkg::MAX_SYMBOLS) ? dhss_pkg::MAX_SYMBOLS : int'(length);
        if (len == 0)
            return answer;
        key = dna_key(symbols, len);
        home = key % TABLE_N;
        stride = 1 + key % (TABLE_N - 1);
        for (longint unsigned i = 0; i < TABLE_N; i++)
        begin
            slot = (home + (i * stride) % TABLE_N) % TABLE_N;
            if (stored_keys[slot] == key[dhss_pkg::KEY_W-1:0])
            begin
                answer.found = 1'b1;
                return answer;
            end
            if (stored_keys[slot] == '0)
            begin
                if (op == dhss_pkg::OP_INSERT)
                    stored_keys[slot] = key[dhss_pkg::KEY_W-1:0];
                return answer;
            end
        end
        answer.full_res = 1'b1;
        return answer;
    endfunction

    task automatic send_request(dhss_pkg::opcode_t op,
                                logic [dhss_pkg::SYMBOLS_W-1:0] symbols,
                                logic [dhss_pkg::LENGTH_W-1:0] length);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.opcode  <= op;
        req.symbols <= symbols;
        req.length  <= length;
        do
            @(posedge clk);
        while (!req.ready);
        pending_answers.push_back(lookup_string(op, symbols, length));
    endtask

    always @(posedge clk)
    begin
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_answer
        answer_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected response found=%b full_res=%b",
                             $realtime, rsp.found, rsp.full_res);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (rsp.found !== want.found || rsp.full_res !== want.full_res)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: expected found=%b full_res=%b, got found=%b full_res=%b",
                                 $realtime, want.found, want.full_res, rsp.found,
                                 rsp.full_res);
                end
            end
        end
    end

    // Two keys fill both slots of a probe cycle of stride N/2, so a third key on
    // that cycle runs out of probes.
    task automatic test_probe_cap();
        logic [dhss_pkg::SYMBOLS_W-1:0] sym_k;
        logic [dhss_pkg::SYMBOLS_W-1:0] sym_a;
        logic [dhss_pkg::SYMBOLS_W-1:0] sym_b;
        longint unsigned                key_k;
        longint unsigned                key_a;
        longint unsigned                key_b;
        longint unsigned                home;
        do
        begin
            sym_k = dhss_pkg::SYMBOLS_W'($urandom);
            key_k = dna_key(sym_k, dhss_pkg::MAX_SYMBOLS);
        end
        while (key_k % (TABLE_N - 1) != TABLE_N / 2 - 1);
        home = key_k % TABLE_N;
        do
        begin
            sym_a = dhss_pkg::SYMBOLS_W'($urandom);
            key_a = dna_key(sym_a, dhss_pkg::MAX_SYMBOLS);
        end
        while (key_a % TABLE_N != home || key_a == key_k);
        do
        begin
            sym_b = dhss_pkg::SYMBOLS_W'($urandom);
            key_b = dna_key(sym_b, dhss_pkg::MAX_SYMBOLS);
        end
        while (key_b % TABLE_N != (home + TABLE_N / 2) % TABLE_N || key_b == key_k);
        send_request(dhss_pkg::OP_INSERT, sym_a, dhss_pkg::MAX_SYMBOLS);
        send_request(dhss_pkg::OP_INSERT, sym_b, dhss_pkg::MAX_SYMBOLS);
        send_request(dhss_pkg::OP_FIND, sym_k, dhss_pkg::MAX_SYMBOLS);
        send_request(dhss_pkg::OP_INSERT, sym_k, dhss_pkg::MAX_SYMBOLS);
        send_request(dhss_pkg::OP_FIND, sym_k, dhss_pkg::MAX_SYMBOLS);
        send_request(dhss_pkg::OP_FIND, sym_a, dhss_pkg::MAX_SYMBOLS);
        send_request(dhss_pkg::OP_INSERT, sym_b, dhss_pkg::MAX_SYMBOLS);
    endtask

    task automatic test_edge_cases();
        send_request(dhss_pkg::OP_FIND, 24'h000000, 4'd1);
        send_request(dhss_pkg::OP_INSERT, 24'h000000, 4'd1);
        send_request(dhss_pkg::OP_FIND, 24'hFFFFFC, 4'd1);
        send_request(dhss_pkg::OP_INSERT, 24'h000000, 4'd1);
        send_request(dhss_pkg::OP_INSERT, 24'hFFFFFF, 4'd12);
        send_request(dhss_pkg::OP_FIND, 24'hFFFFFF, 4'd15);
        send_request(dhss_pkg::OP_INSERT, 24'hAAAAAA, 4'd13);
        send_request(dhss_pkg::OP_FIND, 24'hAAAAAA, 4'd12);
        send_request(dhss_pkg::OP_INSERT, 24'h123456, 4'd0);
        send_request(dhss_pkg::OP_FIND, 24'h123456, 4'd0);
        send_request(dhss_pkg::OP_INSERT, 24'h000039, 4'd3);
        send_request(dhss_pkg::OP_FIND, 24'hABCD39, 4'd3);
        send_request(dhss_pkg::OP_INSERT, 24'h000000, 4'd12);
        send_request(dhss_pkg::OP_FIND, 24'h000000, 4'd11);
        send_request(dhss_pkg::OP_FIND, 24'h555555, 4'd14);
        send_request(dhss_pkg::OP_INSERT, 24'h555555, 4'd14);
        send_request(dhss_pkg::OP_FIND, 24'h555555, 4'd12);
        send_request(dhss_pkg::OP_INSERT, 24'hFFFFFF, 4'd12);
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        int                             pick;
        int                             len;
        logic [dhss_pkg::SYMBOLS_W-1:0] sym;
        logic [dhss_pkg::SYMBOLS_W-1:0] keep_mask;
        dna_string_t                    old;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            sym = dhss_pkg::SYMBOLS_W'($urandom);
            if (pick < 40 || inserted_strings.size() == 0)
            begin
                len = $urandom_range(1, dhss_pkg::MAX_SYMBOLS);
                inserted_strings.push_back('{symbols: sym,
                                             length: dhss_pkg::LENGTH_W'(len)});
                send_request(dhss_pkg::OP_INSERT, sym, dhss_pkg::LENGTH_W'(len));
            end
            else if (pick < 75)
            begin
                old = inserted_strings[$urandom_range(inserted_strings.size() - 1)];
                keep_mask = (old.length >= dhss_pkg::MAX_SYMBOLS) ? '1
                          : dhss_pkg::SYMBOLS_W'((dhss_pkg::SYMBOLS_W'(1)
                                                  << (2 * old.length)) - 1);
                send_request(dhss_pkg::opcode_t'($urandom_range(1)),
                             (old.symbols & keep_mask) | (sym & ~keep_mask), old.length);
            end
            else if (pick < 95)
                send_request(dhss_pkg::OP_FIND, sym,
                             dhss_pkg::LENGTH_W'($urandom_range(1, dhss_pkg::MAX_SYMBOLS)));
            else
                send_request(dhss_pkg::opcode_t'($urandom_range(1)), sym,
                             ($urandom_range(1) == 0) ? dhss_pkg::LENGTH_W'(0)
                             : dhss_pkg::LENGTH_W'($urandom_range(dhss_pkg::MAX_SYMBOLS + 1,
                                                                  15)));
        end
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_N; i++)
            stored_keys[i] = '0;
        mismatch_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n       <= 1'b0;
        req.valid   <= 1'b0;
        req.opcode  <= dhss_pkg::OP_FIND;
        req.symbols <= '0;
        req.length  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_probe_cap();
        test_edge_cases();
        test_random(350, 0, 0);
        test_random(350, 55, 0);
        test_random(350, 0, 55);
        test_random(350, 16, 16);
        req.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
